// File: design/gacp_pkg.sv
// Shared types and constants for the glyph atlas channel packer.
// No dependencies; used by gacp_pad and glyph_atlas_channel_packer.
package gacp_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BmpW     = 10;
  localparam int unsigned BearW    = 11;
  localparam int unsigned PadSzW   = 11;
  localparam int unsigned OffW     = 12;
  localparam int unsigned OutCrdW  = 16;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned MovesW   = 16;

  typedef enum logic [0:0] {
    CfgPadding = 1'b0,
    CfgSpread  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic        [PadSzW-1:0] padded_width;
    logic        [PadSzW-1:0] padded_height;
    logic signed [OffW-1:0]   offset_x;
    logic signed [OffW-1:0]   offset_y;
  } pad_t;

endpackage

// File: design/gacp_pad.sv
// Border arithmetic: padded glyph size and bitmap offsets from padding and spread.
// Depends on gacp_pkg.
module gacp_pad (
  input  logic [gacp_pkg::CfgDataW-1:0]     padding_i,
  input  logic [gacp_pkg::CfgDataW-1:0]     spread_i,
  input  logic [gacp_pkg::BmpW-1:0]         bitmap_width_i,
  input  logic [gacp_pkg::BmpW-1:0]         bitmap_height_i,
  input  logic signed [gacp_pkg::BearW-1:0] bearing_left_i,
  input  logic signed [gacp_pkg::BearW-1:0] bearing_top_i,
  output gacp_pkg::pad_t                    pad_o
);

  logic [gacp_pkg::CfgDataW:0]   border;
  logic [gacp_pkg::PadSzW-1:0]   border2;
  logic [gacp_pkg::OffW-1:0]     border_ext;
  logic [gacp_pkg::OffW-1:0]     left_ext;
  logic [gacp_pkg::OffW-1:0]     top_ext;
  logic [gacp_pkg::OffW-1:0]     top_sum;

  assign border     = {1'b0, padding_i} + {1'b0, spread_i};
  assign border2    = gacp_pkg::PadSzW'({border, 1'b0});
  assign border_ext = gacp_pkg::OffW'(border);
  assign left_ext   = {bearing_left_i[gacp_pkg::BearW-1], bearing_left_i};
  assign top_ext    = {bearing_top_i[gacp_pkg::BearW-1], bearing_top_i};
  assign top_sum    = top_ext + border_ext;

  assign pad_o.padded_width  = gacp_pkg::PadSzW'(bitmap_width_i) + border2;
  assign pad_o.padded_height = gacp_pkg::PadSzW'(bitmap_height_i) + border2;
  assign pad_o.offset_x      = left_ext + border_ext;
  assign pad_o.offset_y      = {gacp_pkg::OffW{1'b0}} - top_sum;

endmodule

// File: design/glyph_atlas_channel_packer.sv
// Glyph atlas channel packer top level: input word register, packing state, result register.
// Depends on gacp_pkg and gacp_pad.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one glyph word: bitmap size and
//   bearings. Output channel (out_valid_o / out_ready_i) carries one placement word
//   per glyph: atlas position, channel, padded size, offsets and running atlas size.
//   padding and spread are written through cfg_we_i / cfg_index_i / cfg_data_i while
//   the block is idle; they apply to every later glyph.
//   An accepted word sits in the input register and passes through the placement logic
//   into the result register once that register is empty or its word is being taken.
//   Throughput is one glyph per cycle while the receiver does not stall; the per-channel
//   corner update and the saturating add plus extent compare settle within that cycle.
//   When the receiver stalls, the result register holds its word and the input
//   register still takes one more glyph; in_ready_o falls only when both are full.
//   Reset clears all corners and extents, selects channel 0 growing across with one
//   move per pass, and sets padding and spread to zero. No results are pending.
module glyph_atlas_channel_packer #(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [gacp_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gacp_pkg::BmpW-1:0]           bitmap_width_i,
  input  logic [gacp_pkg::BmpW-1:0]           bitmap_height_i,
  input  logic signed [gacp_pkg::BearW-1:0]   bearing_left_i,
  input  logic signed [gacp_pkg::BearW-1:0]   bearing_top_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gacp_pkg::OutCrdW-1:0]        tex_x_o,
  output logic [gacp_pkg::OutCrdW-1:0]        tex_y_o,
  output logic [gacp_pkg::ChanW-1:0]          channel_o,
  output logic [gacp_pkg::PadSzW-1:0]         padded_width_o,
  output logic [gacp_pkg::PadSzW-1:0]         padded_height_o,
  output logic signed [gacp_pkg::OffW-1:0]    offset_x_o,
  output logic signed [gacp_pkg::OffW-1:0]    offset_y_o,
  output logic [gacp_pkg::OutCrdW-1:0]        atlas_width_o,
  output logic [gacp_pkg::OutCrdW-1:0]        atlas_height_o
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChIdxW-1:0] LastCh = ChIdxW'(CHANNELS - 1);
  localparam logic [COORD_BITS-1:0] CrdMax = {COORD_BITS{1'b1}};

  // configuration
  logic [gacp_pkg::CfgDataW-1:0] padding_q, spread_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padding_q <= '0;
      spread_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (gacp_pkg::cfg_reg_e'(cfg_index_i))
        gacp_pkg::CfgPadding: padding_q <= cfg_data_i;
        gacp_pkg::CfgSpread:  spread_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word register
  logic                              in_valid_q, in_valid_d;
  logic [gacp_pkg::BmpW-1:0]         bw_q, bh_q;
  logic signed [gacp_pkg::BearW-1:0] bl_q, bt_q;
  logic                              advance, fire, in_accept;

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bw_q <= bitmap_width_i;
      bh_q <= bitmap_height_i;
      bl_q <= bearing_left_i;
      bt_q <= bearing_top_i;
    end
  end

  gacp_pkg::pad_t pad;

  gacp_pad u_pad (
    .padding_i       (padding_q),
    .spread_i        (spread_q),
    .bitmap_width_i  (bw_q),
    .bitmap_height_i (bh_q),
    .bearing_left_i  (bl_q),
    .bearing_top_i   (bt_q),
    .pad_o           (pad)
  );

  // packing state
  logic [COORD_BITS-1:0]     start_x_q [CHANNELS];
  logic [COORD_BITS-1:0]     start_y_q [CHANNELS];
  logic [COORD_BITS-1:0]     ext_x_q   [CHANNELS];
  logic [COORD_BITS-1:0]     ext_y_q   [CHANNELS];
  logic [COORD_BITS-1:0]     start_x_d [CHANNELS];
  logic [COORD_BITS-1:0]     start_y_d [CHANNELS];
  logic [COORD_BITS-1:0]     ext_x_d   [CHANNELS];
  logic [COORD_BITS-1:0]     ext_y_d   [CHANNELS];
  logic                      grow_down_q, grow_down_d;
  logic [gacp_pkg::MovesW-1:0] moves_done_q, moves_done_d, moves_inc;
  logic [gacp_pkg::MovesW-1:0] moves_pass_q, moves_pass_d;
  logic [ChIdxW-1:0]         ch_q, ch_d;
  logic [COORD_BITS-1:0]     atlas_w_q, atlas_w_d, atlas_h_q, atlas_h_d;

  logic [COORD_BITS:0]       sum_x, sum_y;
  logic [COORD_BITS-1:0]     sat_x, sat_y, new_ext_x, new_ext_y;
  logic                      wrap, pass_end;

  assign sum_x     = {1'b0, start_x_q[ch_q]} + (COORD_BITS + 1)'(pad.padded_width);
  assign sum_y     = {1'b0, start_y_q[ch_q]} + (COORD_BITS + 1)'(pad.padded_height);
  assign sat_x     = sum_x[COORD_BITS] ? CrdMax : sum_x[COORD_BITS-1:0];
  assign sat_y     = sum_y[COORD_BITS] ? CrdMax : sum_y[COORD_BITS-1:0];
  assign new_ext_x = (sat_x > ext_x_q[ch_q]) ? sat_x : ext_x_q[ch_q];
  assign new_ext_y = (sat_y > ext_y_q[ch_q]) ? sat_y : ext_y_q[ch_q];
  assign wrap      = (ch_q == LastCh);
  assign moves_inc = moves_done_q + 1'b1;
  assign pass_end  = wrap && (moves_inc == moves_pass_q);

  always_comb begin
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    ext_x_d      = ext_x_q;
    ext_y_d      = ext_y_q;
    grow_down_d  = grow_down_q;
    moves_done_d = moves_done_q;
    moves_pass_d = moves_pass_q;
    ch_d         = ch_q;
    atlas_w_d    = atlas_w_q;
    atlas_h_d    = atlas_h_q;
    if (fire) begin
      ext_x_d[ch_q] = new_ext_x;
      ext_y_d[ch_q] = new_ext_y;
      atlas_w_d     = (new_ext_x > atlas_w_q) ? new_ext_x : atlas_w_q;
      atlas_h_d     = (new_ext_y > atlas_h_q) ? new_ext_y : atlas_h_q;
      ch_d          = wrap ? '0 : ch_q + 1'b1;
      if (wrap) begin
        moves_done_d = moves_inc;
      end
      if (pass_end) begin
        moves_done_d = '0;
        grow_down_d  = !grow_down_q;
        for (int k = 0; k < CHANNELS; k++) begin
          if (!grow_down_q) begin
            start_x_d[k] = ext_x_d[k];
            start_y_d[k] = '0;
          end else begin
            start_x_d[k] = '0;
            start_y_d[k] = ext_y_d[k];
          end
        end
        if (grow_down_q && (moves_pass_q != {gacp_pkg::MovesW{1'b1}})) begin
          moves_pass_d = moves_pass_q + 1'b1;
        end
      end else if (grow_down_q) begin
        start_y_d[ch_q] = sat_y;
      end else begin
        start_x_d[ch_q] = sat_x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) begin
        start_x_q[k] <= '0;
        start_y_q[k] <= '0;
        ext_x_q[k]   <= '0;
        ext_y_q[k]   <= '0;
      end
      grow_down_q  <= 1'b0;
      moves_done_q <= '0;
      moves_pass_q <= gacp_pkg::MovesW'(1);
      ch_q         <= '0;
      atlas_w_q    <= '0;
      atlas_h_q    <= '0;
    end else begin
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      ext_x_q      <= ext_x_d;
      ext_y_q      <= ext_y_d;
      grow_down_q  <= grow_down_d;
      moves_done_q <= moves_done_d;
      moves_pass_q <= moves_pass_d;
      ch_q         <= ch_d;
      atlas_w_q    <= atlas_w_d;
      atlas_h_q    <= atlas_h_d;
    end
  end

  // result register
  logic out_valid_q, out_valid_d;

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tex_x_o         <= gacp_pkg::OutCrdW'(start_x_q[ch_q]);
      tex_y_o         <= gacp_pkg::OutCrdW'(start_y_q[ch_q]);
      channel_o       <= gacp_pkg::ChanW'(ch_q);
      padded_width_o  <= pad.padded_width;
      padded_height_o <= pad.padded_height;
      offset_x_o      <= pad.offset_x;
      offset_y_o      <= pad.offset_y;
      atlas_width_o   <= gacp_pkg::OutCrdW'(atlas_w_d);
      atlas_height_o  <= gacp_pkg::OutCrdW'(atlas_h_d);
    end
  end

endmodule
